>>> sv/swm_pkg.sv
package swm_pkg;

	localparam int MAX_WINDOW   = 16;
	localparam int SAMPLE_WIDTH = 16;
	localparam int IDX_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
	localparam int CFG_W        = 5;
	localparam int RESET_WINDOW = (5 > MAX_WINDOW) ? MAX_WINDOW : 5;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [SAMPLE_WIDTH:0]   median_t;
	typedef logic [IDX_W-1:0]               age_t;
	typedef logic [CNT_W-1:0]               count_t;

	// Link from a cell to its right-hand neighbor.
	typedef struct packed {
		logic    valid;
		logic    mv_right;
		sample_t val;
		age_t    age;
		logic    evict_seen;
	} fwd_link_t;

	// Link from a cell to its left-hand neighbor.
	typedef struct packed {
		logic    mv_left;
		sample_t val;
		age_t    age;
	} bwd_link_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic    accept;
		logic    clear;
		sample_t x;
		age_t    win_last;
		logic    any_evict;
	} cell_cmd_t;

endpackage

>>> sv/sliding_window_median_filter.sv
// Timing: the sorted cell chain updates at the edge that accepts a sample transaction, and
// the median is registered into the output stage once the output register is empty or
// being drained. Throughput: one sample per cycle while the receiver takes each result;
// the input stalls only while a computed median waits behind an output register that
// the receiver has not taken.
// Reset (arst_n, asynchronous, active low) empties the window and sets the window size
// to five; a nonzero window_size write empties the window as well.
module sliding_window_median_filter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  swm_pkg::sample_t     sample,
	output logic                 median_valid,
	input  logic                 median_ready,
	output swm_pkg::median_t     median_doubled,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [swm_pkg::CFG_W-1:0] window_size
);
	import swm_pkg::*;

	// The window lives in a chain of cells kept in ascending order. Each cell holds
	// one sample and its age; a new sample is inserted in place while the oldest one
	// of a full window is removed, with cells taking values from their neighbors.
	fwd_link_t fwd [MAX_WINDOW+1];
	bwd_link_t bwd [MAX_WINDOW+1];
	cell_cmd_t cmd;

	count_t  win_q;
	count_t  count_q;
	logic    pend_q;
	logic    out_valid_q;
	median_t median_q;

	logic    in_fire;
	logic    cfg_fire;
	logic    do_clear;
	logic    cap;
	count_t  win_d;
	age_t    lo_idx;
	age_t    hi_idx;
	sample_t lo_val;
	sample_t hi_val;

	// Always taken; the user issues a configuration only while idle, unchecked.
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	// A write of zero is ignored altogether.
	assign do_clear  = cfg_fire && (window_size != '0);

	always_comb begin
		if (int'(window_size) > MAX_WINDOW) begin
			win_d = count_t'(MAX_WINDOW);
		end else begin
			win_d = count_t'(window_size);
		end
	end

	// The output stage is loaded when the chain holds an updated window that has not
	// yet been reduced, and the output register is empty or being drained.
	assign cap          = pend_q && (!out_valid_q || median_ready);
	assign sample_ready = !pend_q || cap;
	assign in_fire      = sample_valid && sample_ready;

	assign cmd.accept    = in_fire;
	assign cmd.clear     = do_clear;
	assign cmd.x         = sample;
	assign cmd.win_last  = age_t'(win_q - count_t'(1));
	assign cmd.any_evict = fwd[MAX_WINDOW].evict_seen;

	// The left end of the chain acts as an always-occupied, never-moving neighbor.
	assign fwd[0].valid      = 1'b1;
	assign fwd[0].mv_right   = 1'b0;
	assign fwd[0].val        = '0;
	assign fwd[0].age        = '0;
	assign fwd[0].evict_seen = 1'b0;

	assign bwd[MAX_WINDOW].mv_left = 1'b0;
	assign bwd[MAX_WINDOW].val     = '0;
	assign bwd[MAX_WINDOW].age     = '0;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_in   (fwd[i]),
			.right_in  (bwd[i+1]),
			.right_out (fwd[i+1]),
			.left_out  (bwd[i])
		);
	end

	// For an odd count both middle indexes coincide, so the sum is twice the median;
	// for an even count it is the sum of the two middle samples.
	assign lo_idx = age_t'((count_q - count_t'(1)) >> 1);
	assign hi_idx = age_t'(count_q >> 1);

	always_comb begin
		lo_val = '0;
		hi_val = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (age_t'(i) == lo_idx) begin
				lo_val = fwd[i+1].val;
			end
			if (age_t'(i) == hi_idx) begin
				hi_val = fwd[i+1].val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= count_t'(RESET_WINDOW);
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_clear) begin
				win_q   <= win_d;
				count_q <= '0;
			end else if (in_fire && (count_q != win_q)) begin
				count_q <= count_q + count_t'(1);
			end

			if (in_fire) begin
				pend_q <= 1'b1;
			end else if (cap) begin
				pend_q <= 1'b0;
			end

			if (cap) begin
				out_valid_q <= 1'b1;
			end else if (median_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			median_q <= median_t'(lo_val) + median_t'(hi_val);
		end
	end

	assign median_valid   = out_valid_q;
	assign median_doubled = median_q;

endmodule

>>> sv/swm_cell.sv
module swm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  swm_pkg::cell_cmd_t cmd,
	input  swm_pkg::fwd_link_t left_in,
	input  swm_pkg::bwd_link_t right_in,
	output swm_pkg::fwd_link_t right_out,
	output swm_pkg::bwd_link_t left_out
);
	import swm_pkg::*;

	logic    valid_q;
	sample_t val_q;
	age_t    age_q;

	logic    evict;
	logic    kept;
	logic    gt;
	logic    after;
	logic    stay;
	logic    valid_d;
	sample_t val_d;
	age_t    age_d;

	// The cell holding the oldest sample of a full window drops it. Kept samples
	// above the new one slide right if they sit before the dropped slot, kept
	// samples at or below it slide left if they sit after it.
	always_comb begin
		evict = valid_q && (age_q == cmd.win_last);
		kept  = valid_q && !evict;
		gt    = val_q > cmd.x;
		after = left_in.evict_seen;
		stay  = kept && (gt == after);

		right_out.valid      = valid_q;
		right_out.mv_right   = kept && gt && !after;
		right_out.val        = val_q;
		right_out.age        = age_q;
		right_out.evict_seen = left_in.evict_seen || evict;

		left_out.mv_left = kept && !gt && after;
		left_out.val     = val_q;
		left_out.age     = age_q;

		valid_d = cmd.any_evict ? valid_q : (valid_q || left_in.valid);
		priority if (stay) begin
			val_d = val_q;
			age_d = age_q + age_t'(1);
		end else if (left_in.mv_right) begin
			val_d = left_in.val;
			age_d = left_in.age + age_t'(1);
		end else if (right_in.mv_left) begin
			val_d = right_in.val;
			age_d = right_in.age + age_t'(1);
		end else begin
			val_d = cmd.x;
			age_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.accept) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q <= val_d;
			age_q <= age_d;
		end
	end

endmodule
